// File: sv/rgs_pkg.sv
package rgs_pkg;

	localparam int MAX_RADIUS_DEF = 3;

	localparam int COORD_W   = 13;
	localparam int LEVEL_W   = 8;
	localparam int GAIN_W    = 16;
	localparam int RAD_W     = 6;
	localparam int PIX_W     = 12;
	localparam int ADD_W     = 24;
	localparam int FALL_W    = 16;
	localparam int RAD2_W    = 12;
	localparam int RSQ_W     = 24;
	localparam int MUL_A_W   = 24;
	localparam int MUL_B_W   = 16;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int FRAME_W   = 13;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

	localparam logic [FRAME_W-1:0] FRAME_LIMIT = 13'd4096;
	localparam logic [FRAME_W-1:0] FRAME_W_RST = 13'd640;
	localparam logic [FRAME_W-1:0] FRAME_H_RST = 13'd480;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RAD2,
		S_RSQ,
		S_LG0,
		S_LG1,
		S_LG2,
		S_LGE,
		S_SCAN,
		S_NUMSQ,
		S_DIVLD,
		S_DIV,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_MULE
	} state_t;

endpackage

// File: sv/rgs_mul.sv
// Shared multiplier, one registered product per cycle.
module rgs_mul (
	input  logic                          clk,
	input  logic [rgs_pkg::MUL_A_W-1:0]   a,
	input  logic [rgs_pkg::MUL_B_W-1:0]   b,
	output logic [rgs_pkg::MUL_P_W-1:0]   p
);

	logic [rgs_pkg::MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= rgs_pkg::MUL_P_W'(a) * rgs_pkg::MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

// File: sv/rgs_div.sv
// Restoring divider, one quotient bit per cycle.
// Needs dividend < divisor; returns floor(dividend * 2^FALL_W / divisor).
module rgs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rgs_pkg::RSQ_W-1:0]    dividend,
	input  logic [rgs_pkg::RSQ_W-1:0]    divisor,
	output logic                         done,
	output logic [rgs_pkg::FALL_W-1:0]   quot
);

	localparam int CNT_W = $clog2(rgs_pkg::FALL_W);

	logic [rgs_pkg::RSQ_W-1:0]  rem_q;
	logic [rgs_pkg::RSQ_W-1:0]  dsr_q;
	logic [rgs_pkg::FALL_W-1:0] quot_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [rgs_pkg::RSQ_W:0]    trial;
	logic                       fits;

	assign trial = {rem_q, 1'b0};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(rgs_pkg::FALL_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= rgs_pkg::RSQ_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= rgs_pkg::RSQ_W'(trial);
			end
			quot_q <= {quot_q[rgs_pkg::FALL_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: sv/radial_glow_splatter.sv
// Channel   Handshake            Payload
// start     start / busy         center_x, center_y, *_level, glow_gain, glow_radius
// result    strobe (no stall)    pixel_x, pixel_y, add_red/green/blue, last_of_run
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A word is taken when start is high and busy is low; busy drops in the cycle
// that carries the last result of that particle. Setup runs through S_RAD2 to
// S_LGE; the scan then takes one window position per cycle ((2*ceil(r)+1)^2
// positions), but leaves it for each pixel inside the disc, which goes through
// the bit-serial falloff divider; the center pixel skips it. Radius 3.0 has 49
// window positions and 28 divider pixels besides the center. Results leave on a
// one-cycle strobe and cannot be held off. Reset clears the control state and
// loads the frame size 640 x 480. A zero radius word is taken and yields nothing.
module radial_glow_splatter #(
	parameter int MAX_RADIUS = rgs_pkg::MAX_RADIUS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              start,
	output logic                              busy,
	input  logic signed [rgs_pkg::COORD_W-1:0] center_x,
	input  logic signed [rgs_pkg::COORD_W-1:0] center_y,
	input  logic [rgs_pkg::LEVEL_W-1:0]       red_level,
	input  logic [rgs_pkg::LEVEL_W-1:0]       green_level,
	input  logic [rgs_pkg::LEVEL_W-1:0]       blue_level,
	input  logic [rgs_pkg::GAIN_W-1:0]        glow_gain,
	input  logic [rgs_pkg::RAD_W-1:0]         glow_radius,

	output logic                              strobe,
	output logic [rgs_pkg::PIX_W-1:0]         pixel_x,
	output logic [rgs_pkg::PIX_W-1:0]         pixel_y,
	output logic [rgs_pkg::ADD_W-1:0]         add_red,
	output logic [rgs_pkg::ADD_W-1:0]         add_green,
	output logic [rgs_pkg::ADD_W-1:0]         add_blue,
	output logic                              last_of_run,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rgs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rgs_pkg::FRAME_W-1:0]       cfg_data
);

	// half-window width and signed offset width
	localparam int HW        = $clog2(MAX_RADIUS + 1);
	localparam int OW        = HW + 1;
	localparam int D2W       = 2 * HW + 1;
	localparam int CMPW      = D2W + 12;
	localparam int RAD_LIMIT = MAX_RADIUS * 16;

	rgs_pkg::state_t state_q, state_d;

	// config
	logic [rgs_pkg::FRAME_W-1:0] frame_w_q, frame_h_q;
	logic [rgs_pkg::FRAME_W-1:0] w_eff, h_eff;

	// per-particle operands
	logic signed [rgs_pkg::COORD_W-1:0] cx_q, cy_q;
	logic [rgs_pkg::LEVEL_W-1:0]  lv0_q, lv1_q, lv2_q;
	logic [rgs_pkg::GAIN_W-1:0]   gain_q;
	logic [rgs_pkg::RAD_W-1:0]    rad_q;
	logic [HW-1:0]                half_q;
	logic [rgs_pkg::RAD2_W-1:0]   rad2_q;
	logic [rgs_pkg::RSQ_W-1:0]    rsq_q;
	logic [rgs_pkg::MUL_A_W-1:0]  lg0_q, lg1_q, lg2_q;

	// scan
	logic signed [OW-1:0]         dx_q, dy_q;
	logic [rgs_pkg::PIX_W-1:0]    cand_x_q, cand_y_q;
	logic [rgs_pkg::RAD2_W-1:0]   num_q;
	logic [rgs_pkg::FALL_W-1:0]   fall_q;
	logic                         scan_end_q;
	logic                         pend_q;

	// result hold
	logic [rgs_pkg::PIX_W-1:0]    hold_x_q, hold_y_q;
	logic [rgs_pkg::ADD_W-1:0]    hold_r_q, hold_g_q, hold_b_q;
	logic                         strobe_q, last_q;

	// control from the sequencer
	logic                         accept;
	logic                         emit, emit_last, div_start;
	logic [rgs_pkg::MUL_A_W-1:0]  mul_a;
	logic [rgs_pkg::MUL_B_W-1:0]  mul_b;
	logic [rgs_pkg::MUL_P_W-1:0]  mul_p;
	logic                         div_done;
	logic [rgs_pkg::FALL_W-1:0]   div_quot;

	// input-side radius clamp and half-size ceil(r)
	logic [rgs_pkg::RAD_W-1:0]    rad_c;
	logic [HW-1:0]                half_c;

	// candidate evaluation
	logic [HW-1:0]                adx, ady;
	logic [D2W-1:0]               d2;
	logic signed [rgs_pkg::COORD_W:0] px, py;
	logic                         in_disc, in_frame, kept, last_cand;

	assign busy      = state_q != rgs_pkg::S_IDLE;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign rad_c  = ({1'b0, glow_radius} > 7'(RAD_LIMIT)) ? rgs_pkg::RAD_W'(RAD_LIMIT)
		: glow_radius;
	assign half_c = HW'((7'(rad_c) + 7'd15) >> 4);

	assign w_eff = (frame_w_q > rgs_pkg::FRAME_LIMIT) ? rgs_pkg::FRAME_LIMIT : frame_w_q;
	assign h_eff = (frame_h_q > rgs_pkg::FRAME_LIMIT) ? rgs_pkg::FRAME_LIMIT : frame_h_q;

	assign adx = dx_q[OW-1] ? HW'(unsigned'(-dx_q)) : HW'(unsigned'(dx_q));
	assign ady = dy_q[OW-1] ? HW'(unsigned'(-dy_q)) : HW'(unsigned'(dy_q));
	assign d2  = D2W'(adx * adx) + D2W'(ady * ady);

	// disc test: 256*d2 <= r^2 (Q4.8)
	assign in_disc = (CMPW'(d2) << 8) <= CMPW'(rad2_q);

	assign px = (rgs_pkg::COORD_W+1)'(cx_q) + (rgs_pkg::COORD_W+1)'(dx_q);
	assign py = (rgs_pkg::COORD_W+1)'(cy_q) + (rgs_pkg::COORD_W+1)'(dy_q);
	assign in_frame = !px[rgs_pkg::COORD_W] && !py[rgs_pkg::COORD_W]
		&& (px[rgs_pkg::COORD_W-1:0] < w_eff) && (py[rgs_pkg::COORD_W-1:0] < h_eff);

	assign kept      = in_disc && in_frame;
	assign last_cand = (dx_q == $signed({1'b0, half_q})) && (dy_q == $signed({1'b0, half_q}));

	rgs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	rgs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_p[rgs_pkg::RSQ_W-1:0]),
		.divisor  (rsq_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Sequencer. The multiplier product shows in the state after its operands.
	// A found pixel is held back until the next one is found (or the scan
	// ends), so the final one can carry last_of_run.
	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			rgs_pkg::S_IDLE: begin
				if (accept && rad_c != '0) begin
					state_d = rgs_pkg::S_RAD2;
				end
			end
			rgs_pkg::S_RAD2: begin
				mul_a   = rgs_pkg::MUL_A_W'(rad_q);
				mul_b   = rgs_pkg::MUL_B_W'(rad_q);
				state_d = rgs_pkg::S_RSQ;
			end
			rgs_pkg::S_RSQ: begin
				mul_a   = rgs_pkg::MUL_A_W'(mul_p[rgs_pkg::RAD2_W-1:0]);
				mul_b   = rgs_pkg::MUL_B_W'(mul_p[rgs_pkg::RAD2_W-1:0]);
				state_d = rgs_pkg::S_LG0;
			end
			rgs_pkg::S_LG0: begin
				mul_a   = rgs_pkg::MUL_A_W'(lv0_q);
				mul_b   = gain_q;
				state_d = rgs_pkg::S_LG1;
			end
			rgs_pkg::S_LG1: begin
				mul_a   = rgs_pkg::MUL_A_W'(lv1_q);
				mul_b   = gain_q;
				state_d = rgs_pkg::S_LG2;
			end
			rgs_pkg::S_LG2: begin
				mul_a   = rgs_pkg::MUL_A_W'(lv2_q);
				mul_b   = gain_q;
				state_d = rgs_pkg::S_LGE;
			end
			rgs_pkg::S_LGE: begin
				state_d = rgs_pkg::S_SCAN;
			end
			rgs_pkg::S_SCAN: begin
				if (kept) begin
					emit    = pend_q;
					state_d = rgs_pkg::S_NUMSQ;
				end else if (last_cand) begin
					emit      = pend_q;
					emit_last = 1'b1;
					state_d   = rgs_pkg::S_IDLE;
				end
			end
			rgs_pkg::S_NUMSQ: begin
				mul_a   = rgs_pkg::MUL_A_W'(num_q);
				mul_b   = rgs_pkg::MUL_B_W'(num_q);
				state_d = rgs_pkg::S_DIVLD;
			end
			rgs_pkg::S_DIVLD: begin
				// center offset: num^2 == r^4, falloff saturates
				if (mul_p[rgs_pkg::RSQ_W-1:0] >= rsq_q) begin
					state_d = rgs_pkg::S_MUL0;
				end else begin
					div_start = 1'b1;
					state_d   = rgs_pkg::S_DIV;
				end
			end
			rgs_pkg::S_DIV: begin
				if (div_done) begin
					state_d = rgs_pkg::S_MUL0;
				end
			end
			rgs_pkg::S_MUL0: begin
				mul_a   = lg0_q;
				mul_b   = fall_q;
				state_d = rgs_pkg::S_MUL1;
			end
			rgs_pkg::S_MUL1: begin
				mul_a   = lg1_q;
				mul_b   = fall_q;
				state_d = rgs_pkg::S_MUL2;
			end
			rgs_pkg::S_MUL2: begin
				mul_a   = lg2_q;
				mul_b   = fall_q;
				state_d = rgs_pkg::S_MULE;
			end
			rgs_pkg::S_MULE: begin
				if (scan_end_q) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = rgs_pkg::S_IDLE;
				end else begin
					state_d = rgs_pkg::S_SCAN;
				end
			end
			default: begin
				state_d = rgs_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rgs_pkg::S_IDLE;
			frame_w_q <= rgs_pkg::FRAME_W_RST;
			frame_h_q <= rgs_pkg::FRAME_H_RST;
			pend_q    <= 1'b0;
			strobe_q  <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			last_q   <= emit_last;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rgs_pkg::CFG_FRAME_WIDTH:  frame_w_q <= cfg_data;
					rgs_pkg::CFG_FRAME_HEIGHT: frame_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				pend_q <= 1'b0;
			end else if (state_q == rgs_pkg::S_SCAN && kept) begin
				pend_q <= 1'b0;
			end else if (state_q == rgs_pkg::S_MULE) begin
				pend_q <= !scan_end_q;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			rgs_pkg::S_IDLE: begin
				if (accept) begin
					cx_q       <= center_x;
					cy_q       <= center_y;
					lv0_q      <= red_level;
					lv1_q      <= green_level;
					lv2_q      <= blue_level;
					gain_q     <= glow_gain;
					rad_q      <= rad_c;
					half_q     <= half_c;
					dx_q       <= -$signed({1'b0, half_c});
					dy_q       <= -$signed({1'b0, half_c});
					scan_end_q <= 1'b0;
				end
			end
			rgs_pkg::S_RSQ: rad2_q <= mul_p[rgs_pkg::RAD2_W-1:0];
			rgs_pkg::S_LG0: rsq_q  <= mul_p[rgs_pkg::RSQ_W-1:0];
			rgs_pkg::S_LG1: lg0_q  <= mul_p[rgs_pkg::MUL_A_W-1:0];
			rgs_pkg::S_LG2: lg1_q  <= mul_p[rgs_pkg::MUL_A_W-1:0];
			rgs_pkg::S_LGE: lg2_q  <= mul_p[rgs_pkg::MUL_A_W-1:0];
			rgs_pkg::S_SCAN: begin
				// rows outer, columns inner
				if (dx_q == $signed({1'b0, half_q})) begin
					dx_q <= -$signed({1'b0, half_q});
					dy_q <= dy_q + OW'(1);
				end else begin
					dx_q <= dx_q + OW'(1);
				end
				if (kept) begin
					cand_x_q   <= px[rgs_pkg::PIX_W-1:0];
					cand_y_q   <= py[rgs_pkg::PIX_W-1:0];
					num_q      <= rad2_q - rgs_pkg::RAD2_W'({d2, 8'h00});
					scan_end_q <= last_cand;
				end
			end
			rgs_pkg::S_DIVLD: begin
				if (mul_p[rgs_pkg::RSQ_W-1:0] >= rsq_q) begin
					fall_q <= '1;
				end
			end
			rgs_pkg::S_DIV: begin
				if (div_done) begin
					fall_q <= div_quot;
				end
			end
			rgs_pkg::S_MUL1: hold_r_q <= mul_p[rgs_pkg::MUL_P_W-1:rgs_pkg::MUL_P_W-rgs_pkg::ADD_W];
			rgs_pkg::S_MUL2: hold_g_q <= mul_p[rgs_pkg::MUL_P_W-1:rgs_pkg::MUL_P_W-rgs_pkg::ADD_W];
			rgs_pkg::S_MULE: begin
				hold_b_q <= mul_p[rgs_pkg::MUL_P_W-1:rgs_pkg::MUL_P_W-rgs_pkg::ADD_W];
				hold_x_q <= cand_x_q;
				hold_y_q <= cand_y_q;
			end
			default: ;
		endcase
	end

	assign strobe      = strobe_q;
	assign last_of_run = last_q;
	assign pixel_x     = hold_x_q;
	assign pixel_y     = hold_y_q;
	assign add_red     = hold_r_q;
	assign add_green   = hold_g_q;
	assign add_blue    = hold_b_q;

endmodule
